@@ hw/rtl/itcs_pkg.sv @@
// Types and constants shared by the IPv4 transport checksum stream block.
package itcs_pkg;

  localparam logic [7:0]  ProtoUdp      = 8'd17;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [3:0]  MinIhl        = 4'd5;
  localparam logic [15:0] MaxByteIndex  = 16'hFFFF;
  localparam logic [15:0] HdrCksumHi    = 16'd10;
  localparam logic [15:0] HdrCksumLo    = 16'd11;
  localparam logic [15:0] SrcAddrFirst  = 16'd12;
  localparam logic [15:0] DstAddrLast   = 16'd19;
  localparam logic [15:0] TotLenHi      = 16'd2;
  localparam logic [15:0] TotLenLo      = 16'd3;
  localparam logic [15:0] TcpCksumHi    = 16'd16;
  localparam logic [15:0] TcpCksumLo    = 16'd17;
  localparam logic [15:0] UdpPortAHi    = 16'd0;
  localparam logic [15:0] UdpPortALo    = 16'd1;
  localparam logic [15:0] UdpPortBHi    = 16'd2;
  localparam logic [15:0] UdpPortBLo    = 16'd3;
  localparam logic [15:0] UdpLenHi      = 16'd4;
  localparam logic [15:0] UdpLenLo      = 16'd5;
  localparam logic [15:0] UdpCksumHi    = 16'd6;
  localparam logic [15:0] UdpCksumLo    = 16'd7;
  localparam logic [15:0] UdpHdrBytes   = 16'd6;
  localparam logic [5:0]  MinHeaderLen  = 6'd20;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last_byte;
    logic       l4_kind;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] header_checksum;
    logic [15:0] l4_checksum;
    logic        short_packet;
  } result_t;

  typedef struct packed {
    logic [15:0] byte_index;
    logic [5:0]  header_len;
    logic [15:0] total_len;
    logic [15:0] transport_len;
    logic        is_tcp;
    logic [31:0] header_sum;
    logic [31:0] transport_sum;
    logic [15:0] port_word_a;
    logic [15:0] port_word_b;
  } pkt_state_t;

  typedef struct packed {
    logic       valid;
    pkt_state_t state;
  } snapshot_t;

endpackage

@@ hw/rtl/itcs_accum.sv @@
// Input register and per-byte running sums; hands the final packet state on.
module itcs_accum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  itcs_pkg::byte_item_t byte_item,
  output itcs_pkg::snapshot_t  snap,
  input  logic                 snap_take
);

  logic                 iv;
  itcs_pkg::byte_item_t ir;
  itcs_pkg::pkt_state_t st;
  itcs_pkg::pkt_state_t st_next;
  logic                 proc;
  logic                 snap_free;

  logic [15:0] i;
  logic [15:0] v;
  logic [3:0]  ihl;
  logic [5:0]  hl_eff;
  logic [15:0] hl16;
  logic [15:0] tl3;
  logic [15:0] o;
  logic        t_add;

  assign snap_free  = !snap.valid || snap_take;
  assign proc       = iv && (!ir.last_byte || snap_free);
  assign byte_stall = iv && !proc;

  always_comb begin
    i       = st.byte_index;
    v       = i[0] ? {8'h00, ir.pkt_byte} : {ir.pkt_byte, 8'h00};
    ihl     = (ir.pkt_byte[3:0] < itcs_pkg::MinIhl) ? itcs_pkg::MinIhl : ir.pkt_byte[3:0];
    hl_eff  = (i == 16'd0) ? {ihl, 2'b00} : st.header_len;
    hl16    = {10'd0, hl_eff};
    tl3     = {st.total_len[15:8], ir.pkt_byte};
    o       = i - hl16;
    t_add   = 1'b0;
    st_next = st;
    if (i != itcs_pkg::MaxByteIndex) begin
      if (i == 16'd0) begin
        st_next.header_len = hl_eff;
        st_next.is_tcp     = ir.l4_kind;
      end
      if (i == itcs_pkg::TotLenHi) begin
        st_next.total_len[15:8] = ir.pkt_byte;
      end
      if (i == itcs_pkg::TotLenLo) begin
        st_next.total_len[7:0] = ir.pkt_byte;
        if (st.is_tcp) begin
          st_next.transport_len = (tl3 >= hl16) ? (tl3 - hl16) : 16'd0;
        end
      end
      if (i < hl16 && i != itcs_pkg::HdrCksumHi && i != itcs_pkg::HdrCksumLo) begin
        st_next.header_sum = st.header_sum + {16'd0, v};
      end
      if (i >= itcs_pkg::SrcAddrFirst && i <= itcs_pkg::DstAddrLast) begin
        t_add = 1'b1;
      end
      if (i >= hl16) begin
        if (st.is_tcp) begin
          t_add = (o < st.transport_len) && o != itcs_pkg::TcpCksumHi &&
                  o != itcs_pkg::TcpCksumLo;
        end else begin
          priority if (o == itcs_pkg::UdpPortAHi) begin
            st_next.port_word_a[15:8] = ir.pkt_byte;
          end else if (o == itcs_pkg::UdpPortALo) begin
            st_next.port_word_a[7:0] = ir.pkt_byte;
          end else if (o == itcs_pkg::UdpPortBHi) begin
            st_next.port_word_b[15:8] = ir.pkt_byte;
          end else if (o == itcs_pkg::UdpPortBLo) begin
            st_next.port_word_b[7:0] = ir.pkt_byte;
          end else if (o == itcs_pkg::UdpLenHi) begin
            st_next.transport_len[15:8] = ir.pkt_byte;
          end else if (o == itcs_pkg::UdpLenLo) begin
            st_next.transport_len[7:0] = ir.pkt_byte;
          end else begin
            t_add = (o < st.transport_len) && o != itcs_pkg::UdpCksumHi &&
                    o != itcs_pkg::UdpCksumLo;
          end
        end
      end
      if (t_add) begin
        st_next.transport_sum = st.transport_sum + {16'd0, v};
      end
      st_next.byte_index = i + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv         <= 1'b0;
      st         <= '0;
      snap.valid <= 1'b0;
    end else begin
      if (!byte_stall) begin
        iv <= byte_valid;
      end
      if (proc) begin
        st <= ir.last_byte ? '0 : st_next;
      end
      if (proc && ir.last_byte) begin
        snap.valid <= 1'b1;
      end else if (snap_take) begin
        snap.valid <= 1'b0;
      end
    end
    if (byte_valid && !byte_stall) begin
      ir <= byte_item;
    end
    if (proc && ir.last_byte) begin
      snap.state <= st_next;
    end
  end

`ifndef SYNTHESIS
  // A held snapshot is never overwritten before the output stage has taken it.
  assert property (@(posedge clk) disable iff (rst)
    snap.valid && !snap_take |=> snap.valid && $stable(snap.state))
    else $error("snapshot overwritten before it was taken");

  // The last byte of a packet leaves the running state cleared.
  assert property (@(posedge clk) disable iff (rst)
    proc && ir.last_byte |=> st.byte_index == 16'd0 && st.header_sum == 32'd0)
    else $error("packet state not cleared after the final byte");

  // Once a packet has started its header length is at least twenty bytes.
  assert property (@(posedge clk) disable iff (rst)
    st.byte_index != 16'd0 |-> st.header_len >= itcs_pkg::MinHeaderLen)
    else $error("header length below the minimum within a packet");
`endif

endmodule

@@ hw/rtl/itcs_final.sv @@
// Folds the packet sums into checksums and holds the result register.
module itcs_final (
  input  logic                clk,
  input  logic                rst,
  input  itcs_pkg::snapshot_t snap,
  output logic                snap_take,
  output logic                result_valid,
  input  logic                result_stall,
  output itcs_pkg::result_t   result_item
);

  itcs_pkg::pkt_state_t s;
  itcs_pkg::result_t    res;
  logic [15:0] len;
  logic [15:0] wa;
  logic [15:0] wb;
  logic [15:0] wl;
  logic [19:0] extra;
  logic [31:0] tsum;
  logic [16:0] tf1;
  logic [15:0] tf2;
  logic [16:0] hf1;
  logic [15:0] hf2;
  logic [15:0] tck;
  logic [15:0] hl16;
  logic [16:0] hl_tl;
  logic [16:0] hl_udp;
  logic        udp;

  assign snap_take = !result_valid || !result_stall;

  always_comb begin
    s    = snap.state;
    len  = s.transport_len;
    udp  = !s.is_tcp;
    wa   = (len >= 16'd2) ? s.port_word_a :
           (len == 16'd1) ? (s.port_word_a & 16'hFF00) : 16'h0000;
    wb   = (len >= 16'd4) ? s.port_word_b :
           (len == 16'd3) ? (s.port_word_b & 16'hFF00) : 16'h0000;
    wl   = (len >= 16'd6) ? len :
           (len == 16'd5) ? (len & 16'hFF00) : 16'h0000;
    if (udp) begin
      extra = {12'd0, itcs_pkg::ProtoUdp} + {4'd0, len} + {4'd0, wa} + {4'd0, wb} +
              {4'd0, wl};
    end else begin
      extra = {12'd0, itcs_pkg::ProtoTcp} + {4'd0, len};
    end
    tsum = s.transport_sum + {12'd0, extra};
    tf1  = {1'b0, tsum[15:0]} + {1'b0, tsum[31:16]};
    tf2  = tf1[15:0] + {15'd0, tf1[16]};
    tck  = ~tf2;
    if (udp && tck == 16'h0000) begin
      tck = 16'hFFFF;
    end
    hf1  = {1'b0, s.header_sum[15:0]} + {1'b0, s.header_sum[31:16]};
    hf2  = hf1[15:0] + {15'd0, hf1[16]};
    hl16   = {10'd0, s.header_len};
    hl_tl  = {1'b0, hl16} + {1'b0, len};
    hl_udp = {1'b0, hl16} + {1'b0, itcs_pkg::UdpHdrBytes};
    res.header_checksum = ~hf2;
    res.l4_checksum     = tck;
    res.short_packet    = (s.byte_index < hl16) || (s.byte_index < s.total_len) ||
                          ({1'b0, s.byte_index} < hl_tl) ||
                          (udp && {1'b0, s.byte_index} < hl_udp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (snap_take) begin
      result_valid <= snap.valid;
    end
    if (snap_take && snap.valid) begin
      result_item <= res;
    end
  end

`ifndef SYNTHESIS
  // A waiting snapshot reaches the result register when it is free.
  assert property (@(posedge clk) disable iff (rst)
    snap.valid && !result_valid |=> result_valid)
    else $error("snapshot not moved into a free result register");

  // A result that is not taken is not replaced by the next snapshot.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("pending result replaced before it was taken");
`endif

endmodule

@@ hw/rtl/ipv4_transport_checksum_stream.sv @@
// Top level of the IPv4 header and UDP/TCP transport checksum stream block.
// The block takes one packet byte per cycle in wire order and raises one result per packet,
// carrying the header checksum, the transport checksum with pseudo-header and a short-packet
// flag. Bytes are still taken while a finished result waits at the output. The final byte of
// a packet passes through the input register, the snapshot register and the result register in
// turn before its result is valid. The byte path stalls only when a final byte meets both the
// snapshot and the result register still occupied.
module ipv4_transport_checksum_stream (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  itcs_pkg::byte_item_t byte_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output itcs_pkg::result_t    result_item
);

  itcs_pkg::snapshot_t snap;
  logic                snap_take;

  itcs_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .snap       (snap),
    .snap_take  (snap_take)
  );

  itcs_final u_final (
    .clk          (clk),
    .rst          (rst),
    .snap         (snap),
    .snap_take    (snap_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule
